/* sv/rpc_pkg.sv */
// shared constants, command type and register indexes for the peak clip filter
// no dependencies; imported by every other file of the block but rpc_ram

package rpc_pkg;

	// frame geometry and pixel format
	localparam int MAX_COLS   = 1024;
	localparam int PIXEL_BITS = 16;
	localparam int COL_BITS   = $clog2(MAX_COLS);
	localparam int COLS_BITS  = COL_BITS + 1;
	localparam int ROW_BITS   = 16;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COLS = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_ROWS = CFG_IDX_BITS'(1);
	localparam logic [COLS_BITS-1:0] COLS_RESET = COLS_BITS'(1024);
	localparam logic [ROW_BITS-1:0]  ROWS_RESET = ROW_BITS'(1024);

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [COL_BITS-1:0]   col_t;

	// one classified item for the back end
	typedef struct packed {
		pixel_t pixel;
		col_t   col;
		logic   wr_mid;
		logic   emit;
		logic   has_top;
		logic   has_bottom;
		logic   has_left;
		logic   has_right;
		logic   row_end;
		logic   frame_end;
	} cmd_t;

endpackage

/* sv/rpc_if.sv */
// valid/ready channel interfaces: pixel input, filtered result, register write
// depends on rpc_pkg

interface rpc_pix_if import rpc_pkg::*;;
	logic   valid;
	logic   ready;
	pixel_t pixel_in;
	logic   flush;

	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface rpc_res_if import rpc_pkg::*;;
	logic   valid;
	logic   ready;
	pixel_t pixel_out;
	logic   row_end;
	logic   frame_end;

	modport source (output valid, output pixel_out, output row_end, output frame_end,
		input ready);
	modport sink (input valid, input pixel_out, input row_end, input frame_end,
		output ready);
endinterface

interface rpc_cfg_if import rpc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/raster_peak_clip_filter.sv */
// an item that completes a result passes the command queue, the stage register and then the result register
// throughput: one item per cycle while results are taken; the line buffers give one read and one write each
// a result register lets a new item in while the previous result waits
// cell (r,c) leaves with pixel (r+1,c); flush items drain the last row
// reset clears positions, queue and result register; sizes return to 1024 x 1024
// line buffers are not cleared; no startup pass, items are taken right after reset

module raster_peak_clip_filter import rpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rpc_pix_if.sink   pixels,
	rpc_res_if.source results,
	rpc_cfg_if.sink   cfg
);

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic pop_valid;
	cmd_t pop_cmd;

	// classification and positions
	rpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// decoupling queue
	rpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	// filtering and results
	rpc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_cmd   (pop_cmd),
		.pop     (pop),
		.results (results)
	);

endmodule

/* sv/rpc_ram.sv */
// generic single-write single-read ram with registered read data
// no dependencies; read returns the old word on a same-address write

module rpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/rpc_front.sv */
// front end: register port, raster position tracking and item classification
// depends on rpc_pkg and rpc_if; feeds rpc_queue with cmd_t items

module rpc_front import rpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rpc_pix_if.sink    pixels,
	rpc_cfg_if.sink    cfg,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic [COLS_BITS-1:0] cols_q;
	logic [ROW_BITS-1:0]  rows_q;
	logic [ROW_BITS-1:0]  in_row_q;
	col_t                 in_col_q;
	logic [ROW_BITS-1:0]  out_row_q;
	col_t                 out_col_q;

	logic [COLS_BITS-1:0] cols_eff;
	logic [ROW_BITS-1:0]  rows_eff;
	logic                 accept;
	logic                 filling;
	logic [COLS_BITS-1:0] in_col_nxt;
	logic [COLS_BITS-1:0] out_col_nxt;
	logic [ROW_BITS:0]    out_row_nxt;
	logic [ROW_BITS-1:0]  in_row_inc;
	logic                 in_last;
	logic                 out_last;
	logic                 frame_last;
	logic                 take_fill;
	logic                 take_drain;

	assign pixels.ready = !q_full;
	assign cfg.ready    = 1'b1;
	assign accept       = pixels.valid && pixels.ready;

	// clamp register values to the supported frame size
	always_comb begin
		if (cols_q == '0) begin
			cols_eff = COLS_BITS'(1);
		end else if (cols_q > COLS_BITS'(MAX_COLS)) begin
			cols_eff = COLS_BITS'(MAX_COLS);
		end else begin
			cols_eff = cols_q;
		end
		rows_eff = (rows_q == '0) ? ROW_BITS'(1) : rows_q;
	end

	// position tests
	assign filling     = in_row_q < rows_eff;
	assign in_col_nxt  = {1'b0, in_col_q} + 1'b1;
	assign out_col_nxt = {1'b0, out_col_q} + 1'b1;
	assign out_row_nxt = {1'b0, out_row_q} + 1'b1;
	assign in_row_inc  = in_row_q + 1'b1;
	assign in_last     = in_col_nxt >= cols_eff;
	assign out_last    = out_col_nxt >= cols_eff;
	assign frame_last  = out_last && (out_row_nxt >= {1'b0, rows_eff});

	// flush while filling and pixels while draining are dropped here
	assign take_fill  = accept && filling && !pixels.flush;
	assign take_drain = accept && !filling && pixels.flush;
	assign push       = take_fill || take_drain;

	// classify the item: neighbour presence and end flags
	always_comb begin
		cmd.pixel = pixels.pixel_in;
		if (filling) begin
			cmd.col        = in_col_q;
			cmd.wr_mid     = 1'b1;
			cmd.emit       = in_row_q != '0;
			cmd.has_top    = in_row_q > ROW_BITS'(1);
			cmd.has_bottom = 1'b1;
			cmd.has_left   = in_col_q != '0;
			cmd.has_right  = !in_last;
			cmd.row_end    = in_last;
			cmd.frame_end  = 1'b0;
		end else begin
			cmd.col        = out_col_q;
			cmd.wr_mid     = 1'b0;
			cmd.emit       = 1'b1;
			cmd.has_top    = out_row_q != '0;
			cmd.has_bottom = 1'b0;
			cmd.has_left   = out_col_q != '0;
			cmd.has_right  = !out_last;
			cmd.row_end    = out_last;
			cmd.frame_end  = frame_last;
		end
	end

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (take_fill) begin
			if (in_last) begin
				in_col_q <= '0;
				in_row_q <= in_row_inc;
				if (in_row_inc >= rows_eff) begin
					out_row_q <= in_row_q;
					out_col_q <= '0;
				end
			end else begin
				in_col_q <= COL_BITS'(in_col_nxt);
			end
		end else if (take_drain) begin
			if (frame_last) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else if (out_last) begin
				out_col_q <= '0;
				out_row_q <= ROW_BITS'(out_row_nxt);
			end else begin
				out_col_q <= COL_BITS'(out_col_nxt);
			end
		end
	end

	// frame size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_FRAME_COLS: cols_q <= cfg.data[COLS_BITS-1:0];
				CFG_FRAME_ROWS: rows_q <= cfg.data[ROW_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* sv/rpc_queue.sv */
// short command queue that decouples the front end from the back end
// depends on rpc_pkg

module rpc_queue import rpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	cmd_t                 slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full      = count_q == QCNT_BITS'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/rpc_back.sv */
// back end: line buffers, neighbour compare and clip, result register
// depends on rpc_pkg, rpc_if and rpc_ram

module rpc_back import rpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       pop,
	rpc_res_if.source  results
);

	logic   valid_s2;
	cmd_t   cmd_s2;
	logic   fwd_s2;
	pixel_t left_q;
	logic   out_valid_q;
	pixel_t out_pixel_q;
	logic   out_row_end_q;
	logic   out_frame_end_q;

	logic   out_free;
	logic   adv;
	logic   s2_free;
	logic   fwd;
	logic   upper_we;
	logic   out_load;
	pixel_t mid_c;
	pixel_t mid_r;
	pixel_t upper;
	pixel_t top;
	pixel_t top_m;
	pixel_t bot_m;
	pixel_t left_m;
	pixel_t right_m;
	pixel_t mx;
	logic   peak;
	pixel_t res;

	function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
		pix_max = (a > b) ? a : b;
	endfunction

	// stage handshake
	assign out_free = !out_valid_q || results.ready;
	assign adv      = !cmd_s2.emit || out_free;
	assign s2_free  = !valid_s2 || adv;
	assign pop      = q_valid && s2_free;
	assign upper_we = valid_s2 && cmd_s2.emit && out_free;
	assign out_load = upper_we;

	// upper row written by the item leaving now is not yet in the ram
	assign fwd = valid_s2 && adv && cmd_s2.emit && (cmd_s2.col == q_cmd.col);

	// raw middle row, one copy per read address
	rpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_mid_c (
		.clk   (clk),
		.we    (pop && q_cmd.wr_mid),
		.waddr (q_cmd.col),
		.wdata (q_cmd.pixel),
		.re    (pop),
		.raddr (q_cmd.col),
		.rdata (mid_c)
	);

	rpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_mid_r (
		.clk   (clk),
		.we    (pop && q_cmd.wr_mid),
		.waddr (q_cmd.col),
		.wdata (q_cmd.pixel),
		.re    (pop),
		.raddr (COL_BITS'(q_cmd.col + 1'b1)),
		.rdata (mid_r)
	);

	// filtered upper row
	rpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_upper (
		.clk   (clk),
		.we    (upper_we),
		.waddr (cmd_s2.col),
		.wdata (res),
		.re    (pop),
		.raddr (q_cmd.col),
		.rdata (upper)
	);

	// neighbour compare and clip to the largest neighbour
	always_comb begin
		top     = fwd_s2 ? left_q : upper;
		top_m   = cmd_s2.has_top ? top : '0;
		bot_m   = cmd_s2.has_bottom ? cmd_s2.pixel : '0;
		left_m  = cmd_s2.has_left ? left_q : '0;
		right_m = cmd_s2.has_right ? mid_r : '0;
		mx      = pix_max(pix_max(top_m, bot_m), pix_max(left_m, right_m));
		peak    = (!cmd_s2.has_top || mid_c > top)
			&& (!cmd_s2.has_bottom || mid_c > cmd_s2.pixel)
			&& (!cmd_s2.has_left || mid_c > left_q)
			&& (!cmd_s2.has_right || mid_c > mid_r);
		res     = peak ? mx : mid_c;
	end

	// stage valid and last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			left_q   <= '0;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (adv) begin
				valid_s2 <= 1'b0;
			end
			if (upper_we) begin
				left_q <= res;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s2 <= q_cmd;
			fwd_s2 <= fwd;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2 && cmd_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pixel_q     <= res;
			out_row_end_q   <= cmd_s2.row_end;
			out_frame_end_q <= cmd_s2.frame_end;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.pixel_out = out_pixel_q;
	assign results.row_end   = out_row_end_q;
	assign results.frame_end = out_frame_end_q;

endmodule

/* sv/rpc_checker.sv */
// port-level checks for raster_peak_clip_filter, attached by bind
// depends on rpc_pkg

module rpc_checker import rpc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   pix_valid,
	input logic   pix_ready,
	input logic   res_valid,
	input logic   res_ready,
	input pixel_t res_pixel,
	input logic   res_row_end,
	input logic   res_frame_end
);

	logic [31:0] pend_q;
	logic        pix_acc;
	logic        res_acc;

	assign pix_acc = pix_valid && pix_ready;
	assign res_acc = res_valid && res_ready;

	// items taken minus results delivered, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pix_acc && !res_acc && pend_q != '1) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_acc && !pix_acc && pend_q != '0) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({res_pixel, res_row_end, res_frame_end}))
		else $error("result changed while stalled");

	// last cell of the frame is also last of its row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_frame_end |-> res_row_end)
		else $error("frame end without row end");

	// no result without an earlier item
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> pend_q != '0)
		else $error("result with no item behind it");

endmodule

bind raster_peak_clip_filter rpc_checker u_rpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_valid     (pixels.valid),
	.pix_ready     (pixels.ready),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.res_pixel     (results.pixel_out),
	.res_row_end   (results.row_end),
	.res_frame_end (results.frame_end)
);

/* bench/testbench.sv */
// self-checking bench for raster_peak_clip_filter: streams raster frames with flush tails,
// predicts each filtered cell in its own line-buffer model and checks every result field
// depends on rpc_pkg and the channel interfaces in rpc_if.sv

module testbench import rpc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 10;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 480;
	localparam int MAX_REPORTS   = 10;
	localparam int FILL_COLS     = 128;

	// indexes with no register behind them
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_A = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_B = CFG_IDX_BITS'(3);

	typedef struct packed {
		pixel_t pixel;
		logic   flush;
	} pix_item_t;

	typedef struct packed {
		pixel_t pixel;
		logic   row_end;
		logic   frame_end;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n;

	rpc_pix_if pix_ch();
	rpc_res_if res_ch();
	rpc_cfg_if cfg_ch();

	raster_peak_clip_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	always #CLK_HALF clk = ~clk;

	// items waiting to be driven and filtered cells waiting to come out
	pix_item_t pixel_backlog[$];
	cell_t     pending_cells[$];

	// line-buffer model of the filter
	pixel_t upper_filt[MAX_COLS];
	pixel_t mid_raw[MAX_COLS];
	pixel_t left_filt = '0;
	int unsigned in_row = 0, in_col = 0, out_row = 0, out_col = 0;
	logic [COLS_BITS-1:0] reg_cols = COLS_RESET;
	logic [ROW_BITS-1:0]  reg_rows = ROWS_RESET;

	// pacing and bookkeeping
	int unsigned send_idle_pct = 37;
	int unsigned recv_idle_pct = 63;
	int unsigned hold_at = 32'hFFFF_FFFF;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned accepted_items = 0, ignored_items = 0, stim_items = 0;
	int unsigned cells_seen = 0, frames_seen = 0, reg_writes = 0;
	int unsigned mismatches = 0, quiet_cycles = 0;

	function automatic int unsigned cols_eff();
		if (reg_cols == 0) return 1;
		if (reg_cols > MAX_COLS) return MAX_COLS;
		return reg_cols;
	endfunction

	function automatic int unsigned rows_eff();
		return (reg_rows == 0) ? 1 : reg_rows;
	endfunction

	function automatic int unsigned buf_idx(int unsigned c);
		return (c < MAX_COLS) ? c : MAX_COLS - 1;
	endfunction

	function automatic bit at_frame_start();
		return in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0;
	endfunction

	// clip one cell against the neighbours it has; top and left are already filtered
	function automatic pixel_t clip_cell(int unsigned r, int unsigned c, bit has_bottom,
		pixel_t bottom, int unsigned ncols);
		pixel_t nbrs[$];
		pixel_t v, best, clipped;
		bit peak;
		v = mid_raw[buf_idx(c)];
		peak = 1'b1;
		best = '0;
		if (r > 0) nbrs.push_back(upper_filt[buf_idx(c)]);
		if (has_bottom) nbrs.push_back(bottom);
		if (c > 0) nbrs.push_back(left_filt);
		if (c + 1 < ncols) nbrs.push_back(mid_raw[buf_idx(c + 1)]);
		foreach (nbrs[i]) begin
			if (!(v > nbrs[i])) peak = 1'b0;
			if (nbrs[i] > best) best = nbrs[i];
		end
		// a cell with no neighbours at all is a peak and clips to zero
		clipped = peak ? best : v;
		upper_filt[buf_idx(c)] = clipped;
		left_filt = clipped;
		return clipped;
	endfunction

	// advance the model by one accepted item and queue the cell it releases
	function automatic void clip_step(pixel_t p, logic fl);
		int unsigned ncols, nrows;
		cell_t out_cell;
		bit re, fe;
		ncols = cols_eff();
		nrows = rows_eff();
		if (in_row < nrows) begin
			// flush while pixels are still due is dropped
			if (fl) begin
				ignored_items++;
				return;
			end
			if (in_row > 0) begin
				out_cell.pixel = clip_cell(in_row - 1, in_col, 1'b1, p, ncols);
				out_cell.row_end = (in_col + 1 >= ncols);
				out_cell.frame_end = 1'b0;
				pending_cells.push_back(out_cell);
			end
			mid_raw[buf_idx(in_col)] = p;
			if (in_col + 1 >= ncols) begin
				in_col = 0;
				in_row++;
				if (in_row >= nrows) begin
					out_row = in_row - 1;
					out_col = 0;
				end
			end else begin
				in_col++;
			end
		end else if (!fl) begin
			// pixel while draining is dropped
			ignored_items++;
		end else begin
			re = (out_col + 1 >= ncols);
			fe = re && (out_row + 1 >= nrows);
			out_cell.pixel = clip_cell(out_row, out_col, 1'b0, '0, ncols);
			out_cell.row_end = re;
			out_cell.frame_end = fe;
			pending_cells.push_back(out_cell);
			if (fe) begin
				in_row = 0;
				in_col = 0;
				out_row = 0;
				out_col = 0;
			end else if (re) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
		end
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
		logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			CFG_FRAME_COLS: reg_cols = val[COLS_BITS-1:0];
			CFG_FRAME_ROWS: reg_rows = val[ROW_BITS-1:0];
			default: ;
		endcase
	endfunction

	// pixel driver: takes the next backlog item when the channel is free
	always @(posedge clk) begin : drive_pixels
		pix_item_t nxt;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				accepted_items++;
				clip_step(pix_ch.pixel_in, pix_ch.flush);
			end
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pixel_backlog.pop_front();
					pix_ch.valid <= 1'b1;
					pix_ch.pixel_in <= nxt.pixel;
					pix_ch.flush <= nxt.flush;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver pacing, with one long hold-off once the hold point is reached
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (!hold_done && accepted_items >= hold_at) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result monitor: compare each cell with the oldest prediction
	always @(posedge clk) begin : check_cells
		cell_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.pixel = res_ch.pixel_out;
			got.row_end = res_ch.row_end;
			got.frame_end = res_ch.frame_end;
			cells_seen++;
			if (got.frame_end === 1'b1) frames_seen++;
			if (pending_cells.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected cell: pixel=%0d row_end=%b frame_end=%b",
						got.pixel, got.row_end, got.frame_end);
			end else begin
				want = pending_cells.pop_front();
				if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
					got.frame_end !== want.frame_end) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("cell %0d: expected %0d/%b/%b got %0d/%b/%b",
							cells_seen, want.pixel, want.row_end, want.frame_end,
							got.pixel, got.row_end, got.frame_end);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", quiet_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic push_item(pixel_t p, logic fl, bit counted);
		pixel_backlog.push_back('{pixel: p, flush: fl});
		if (counted) stim_items++;
	endtask

	// wait until everything sent has come out, then let the pipeline go quiet
	task automatic wait_drained();
		do @(negedge clk);
		while (pixel_backlog.size() != 0 || pix_ch.valid || pending_cells.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic set_sizes(int unsigned ncols, int unsigned nrows);
		write_reg(CFG_FRAME_COLS, CFG_DATA_BITS'(ncols));
		write_reg(CFG_FRAME_ROWS, CFG_DATA_BITS'(nrows));
	endtask

	function automatic pixel_t rand_pixel();
		int unsigned sel;
		sel = $urandom_range(99);
		// small values give plateaus and ties, extremes hit the field edges
		if (sel < 30) return pixel_t'($urandom_range(3));
		if (sel < 40) return $urandom_range(1) ? '1 : '0;
		return pixel_t'($urandom);
	endfunction

	function automatic int unsigned rand_cols();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 3) return 0;
		if (sel < 60) return $urandom_range(6, 1);
		if (sel < 90) return $urandom_range(32, 7);
		return $urandom_range(FILL_COLS, 33);
	endfunction

	function automatic int unsigned rand_rows();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 5) return 0;
		if (sel < 65) return $urandom_range(4, 1);
		return $urandom_range(10, 5);
	endfunction

	// one full frame at the current sizes, optionally sprinkled with dropped items
	task automatic push_frame(bit noisy);
		int unsigned ncols, nrows;
		ncols = cols_eff();
		nrows = rows_eff();
		for (int unsigned r = 0; r < nrows; r++)
			for (int unsigned c = 0; c < ncols; c++) begin
				if (noisy && $urandom_range(99) < 4) push_item(rand_pixel(), 1'b1, 1'b0);
				push_item(rand_pixel(), 1'b0, 1'b1);
			end
		for (int unsigned c = 0; c < ncols; c++) begin
			if (noisy && $urandom_range(99) < 4) push_item(rand_pixel(), 1'b0, 1'b0);
			push_item(rand_pixel(), 1'b1, 1'b1);
		end
	endtask

	// after a mid-frame resize, feed one item at a time until the frame closes
	task automatic finish_frame();
		forever begin
			while (pixel_backlog.size() != 0 || pix_ch.valid) @(negedge clk);
			if (at_frame_start()) break;
			if (in_row >= rows_eff())
				push_item(rand_pixel(), 1'b1, 1'b1);
			else
				push_item(rand_pixel(), 1'b0, 1'b1);
		end
	endtask

	initial begin : stimulus
		int unsigned base, done, sel, span;
		int unsigned phase;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_in = '0;
		pix_ch.flush = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_FRAME_COLS;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes: start a 1024-wide row, then shrink it and zero the row count so
		// the next pixel wraps and closes the frame; this fills every column used later
		for (int i = 0; i < FILL_COLS; i++) push_item(rand_pixel(), 1'b0, 1'b1);
		wait_drained();
		set_sizes(FILL_COLS, 0);
		push_item(rand_pixel(), 1'b0, 1'b1);
		for (int i = 0; i < FILL_COLS; i++) push_item(rand_pixel(), 1'b1, 1'b1);
		wait_drained();

		// writes to unmapped indexes change nothing
		write_reg(CFG_UNMAPPED_A, CFG_DATA_BITS'($urandom));
		write_reg(CFG_UNMAPPED_B, CFG_DATA_BITS'($urandom));

		// single-cell frame, with a dropped flush and a dropped pixel around it
		set_sizes(1, 1);
		push_item(16'hFFFF, 1'b1, 1'b1);
		push_item(16'hFFFF, 1'b0, 1'b1);
		push_item(16'h5A5A, 1'b0, 1'b1);
		push_item(16'h0000, 1'b1, 1'b1);
		wait_drained();

		// 3x3 frame with peaks in the middle and in the bottom corners
		set_sizes(3, 3);
		push_item(0, 1'b0, 1'b1);
		push_item(9, 1'b0, 1'b1);
		push_item(0, 1'b0, 1'b1);
		push_item(7, 1'b0, 1'b1);
		push_item(65535, 1'b0, 1'b1);
		push_item(7, 1'b0, 1'b1);
		push_item(65535, 1'b0, 1'b1);
		push_item(3, 1'b0, 1'b1);
		push_item(65535, 1'b0, 1'b1);
		for (int i = 0; i < 3; i++) push_item(16'hFFFF, 1'b1, 1'b1);
		wait_drained();

		// zero columns act as one: a single column of two rows
		set_sizes(0, 2);
		push_item(65535, 1'b0, 1'b1);
		push_item(0, 1'b0, 1'b1);
		push_item(0, 1'b1, 1'b1);
		wait_drained();

		// resize mid-frame: widen past the maximum, then shrink so positions wrap
		set_sizes(3, 65535);
		push_item(65535, 1'b0, 1'b1);
		push_item(0, 1'b0, 1'b1);
		push_item(1, 1'b0, 1'b1);
		push_item(65535, 1'b0, 1'b1);
		wait_drained();
		write_reg(CFG_FRAME_COLS, CFG_DATA_BITS'(2047));
		for (int i = 0; i < 3; i++) push_item(rand_pixel(), 1'b0, 1'b1);
		wait_drained();
		set_sizes(2, 2);
		finish_frame();
		wait_drained();

		// random frames over three pacing phases
		base = stim_items;
		phase = 0;
		while (stim_items - base < RANDOM_ITEMS) begin
			done = stim_items - base;
			if (phase == 0 && done >= RANDOM_ITEMS / 3) begin
				phase = 1;
				send_idle_pct = 63;
				recv_idle_pct = 37;
			end
			if (phase == 1 && done >= 2 * RANDOM_ITEMS / 3) begin
				// no idling; a long frame keeps the sender busy across the output stall
				phase = 2;
				send_idle_pct = 0;
				recv_idle_pct = 0;
				wait_drained();
				set_sizes(16, 12);
				hold_at = accepted_items + 40;
				push_frame(1'b0);
				continue;
			end
			sel = $urandom_range(99);
			if (sel < 8) begin
				// partial frame, then new sizes while it is in progress
				wait_drained();
				set_sizes(rand_cols(), rand_rows());
				span = cols_eff() * rows_eff();
				for (int unsigned i = $urandom_range(span, 1); i > 0; i--)
					push_item(rand_pixel(), 1'b0, 1'b1);
				wait_drained();
				if ($urandom_range(1)) write_reg(CFG_FRAME_COLS, CFG_DATA_BITS'(rand_cols()));
				write_reg(CFG_FRAME_ROWS, CFG_DATA_BITS'(rand_rows()));
				finish_frame();
			end else begin
				if (sel < 60 || done == 0) begin
					wait_drained();
					set_sizes(rand_cols(), rand_rows());
				end
				push_frame(1'b1);
			end
		end

		wait_drained();
		if (pending_cells.size() != 0) begin
			mismatches++;
			$display("%0d expected cells never came out", pending_cells.size());
		end
		$display("run covered %0d items (%0d dropped by the block), %0d cells, %0d frames",
			accepted_items, ignored_items, cells_seen, frames_seen);
		$display("%0d register writes, frames 1x1 to %0d wide, mid-frame resizes, %0d-cycle stall",
			reg_writes, FILL_COLS, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
